// File: hw/rtl/lzs_pkg.sv
// Package: shared constants, request/result types and geometry clamps.
`default_nettype none
package lzs_pkg;
    localparam int MAX_WINDOW_DEF = 15;
    localparam int LINE_COLS      = 1024;
    localparam int COL_BITS       = 10;
    localparam int DIM_BITS       = 11;
    localparam int PIXEL_BITS     = 8;
    localparam int HIST_LEN       = 16;
    localparam int CSUM_BITS      = 12;
    localparam int CSQ_BITS       = 20;
    localparam int WSUM_BITS      = 16;
    localparam int WSQ_BITS       = 24;
    localparam int THR_BITS       = 12;
    localparam int CFG_BITS       = 12;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_THR    = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [3:0]          WIN_RESET    = 4'd9;
    localparam logic [THR_BITS-1:0] THR_RESET    = 12'hE00;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [DIM_BITS-1:0] HEIGHT_CAP   = 11'd1024;
    localparam logic [DIM_BITS-1:0] WIDTH_CAP    = 11'd1024;

    typedef struct packed {
        logic                        start;
        logic                        ack;
        logic [WSUM_BITS-1:0]        s;
        logic [WSQ_BITS-1:0]         q;
        logic [7:0]                  n;
        logic [PIXEL_BITS-1:0]       c;
        logic signed [THR_BITS-1:0]  t;
    } req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic mark;
    } res_t;

    function automatic logic [3:0] clamp_win(input logic [3:0] v, input logic [3:0] cap);
        logic [3:0] w;
        w = v | 4'd1;
        if (w < 4'd3) w = 4'd3;
        if (w > cap) w = cap;
        return w;
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] cap);
        logic [DIM_BITS-1:0] w;
        w = (v == '0) ? DIM_BITS'(1) : v;
        if (w > cap) w = cap;
        return w;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/lzs_judge.sv
// Sequential exact z-score threshold test over squared integer products.
`default_nettype none
module lzs_judge (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire lzs_pkg::req_t req,
    output lzs_pkg::res_t    res
);
    localparam logic [3:0] STEP_DSIG = 4'd0;
    localparam logic [3:0] STEP_NQ   = 4'd1;
    localparam logic [3:0] STEP_V    = 4'd2;
    localparam logic [3:0] STEP_DD   = 4'd3;
    localparam logic [3:0] STEP_TT   = 4'd4;
    localparam logic [3:0] STEP_LA   = 4'd5;
    localparam logic [3:0] STEP_TN   = 4'd6;
    localparam logic [3:0] STEP_RR   = 4'd7;
    localparam logic [3:0] STEP_DEC  = 4'd8;

    logic                       busy_reg, done_reg, mark_reg;
    logic [3:0]                 step_reg;
    logic [lzs_pkg::WSUM_BITS-1:0] s_reg;
    logic [lzs_pkg::WSQ_BITS-1:0]  q_reg;
    logic [7:0]                 n_reg;
    logic [lzs_pkg::PIXEL_BITS-1:0] c_reg;
    logic signed [lzs_pkg::THR_BITS-1:0] t_reg;
    logic signed [17:0]         dsig_reg;
    logic [31:0]                nq_reg, v_reg, dd_reg;
    logic [22:0]                tt_reg;
    logic [39:0]                la_reg;
    logic [30:0]                tn_reg;
    logic [62:0]                rr_reg;

    logic [15:0]                nc;
    logic [15:0]                dabs;
    logic [11:0]                tabs;
    logic [63:0]                lhs, rhs;
    logic                       mark_next;

    always_comb begin
        nc   = 16'(n_reg) * 16'(c_reg);
        dabs = dsig_reg[17] ? 16'(-dsig_reg) : dsig_reg[15:0];
        tabs = t_reg[11] ? 12'(-t_reg) : 12'(t_reg);
        lhs  = {8'd0, la_reg, 16'd0};
        rhs  = {1'b0, rr_reg};
        mark_next = 1'b0;
        if (s_reg != '0 && v_reg != '0 && t_reg > -12'sd1280) begin
            if (dsig_reg[17]) begin
                mark_next = (t_reg >= 0) || (lhs > rhs);
            end else begin
                mark_next = (t_reg > 0) && (lhs < rhs);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_DSIG;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_DSIG;
            s_reg    <= req.s;
            q_reg    <= req.q;
            n_reg    <= req.n;
            c_reg    <= req.c;
            t_reg    <= req.t;
        end else begin
            if (req.ack) done_reg <= 1'b0;
            if (busy_reg) begin
                step_reg <= step_reg + 4'd1;
                case (step_reg)
                    STEP_DSIG: dsig_reg <= $signed({2'b00, nc}) - $signed({2'b00, s_reg});
                    STEP_NQ:   nq_reg   <= 32'(n_reg) * 32'(q_reg);
                    STEP_V:    v_reg    <= nq_reg - 32'(s_reg) * 32'(s_reg);
                    STEP_DD:   dd_reg   <= 32'(dabs) * 32'(dabs);
                    STEP_TT:   tt_reg   <= 23'(tabs) * 23'(tabs);
                    STEP_LA:   la_reg   <= 40'(dd_reg) * 40'(n_reg - 8'd1);
                    STEP_TN:   tn_reg   <= 31'(tt_reg) * 31'(n_reg);
                    STEP_RR:   rr_reg   <= 63'(tn_reg) * 63'(v_reg);
                    STEP_DEC: begin
                        mark_reg <= mark_next;
                        done_reg <= 1'b1;
                        busy_reg <= 1'b0;
                    end
                    default: busy_reg <= 1'b0;
                endcase
            end
        end
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.mark = mark_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("judge started while busy");
    a_done_after_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(step_reg == STEP_DEC)) else $error("judge done early");
    a_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && done_reg)) else $error("judge busy and done");
endmodule
`default_nettype wire

// File: hw/rtl/local_zscore_dark_pixel_segmenter.sv
// Top level: line store, column sums, window sums and result register.
// Flow: an accepted item passes through the read and update states; items that
// give a result then start the judge unit from the centre state. A new item is
// taken only back in idle, after the sequential judge chain and a free output.
// Reset: counters, handshakes and geometry clear; line and column memories
// are not cleared and are always written before read.
`default_nettype none
module local_zscore_dark_pixel_segmenter #(
    parameter int MAX_WINDOW = lzs_pkg::MAX_WINDOW_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // pixel[7:0]
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // mark[0], center_row[10:1], center_col[20:11]
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [11:0] cfg_wdata
);
    localparam int MAXODD   = (MAX_WINDOW - 1) | 1;
    localparam int WCAP     = MAXODD > 15 ? 15 : MAXODD;
    localparam int L        = MAX_WINDOW - 1;
    localparam int SW       = (L > 1) ? $clog2(L) : 1;
    localparam int CB       = lzs_pkg::COL_BITS;
    localparam int DB       = lzs_pkg::DIM_BITS;
    localparam int HB       = $clog2(lzs_pkg::HIST_LEN);
    localparam logic [3:0] WCAP_V = 4'(WCAP);
    localparam logic [SW:0] L_V   = (SW+1)'(L);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_CTR  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0] st_reg;
    logic [3:0] win_reg;
    logic signed [11:0] thr_reg;
    logic [DB-1:0] w_reg, h_reg;
    logic [3:0] gwin_reg;
    logic [DB-1:0] gw_reg, gh_reg;
    logic [CB-1:0] x_reg, y_reg;
    logic [SW-1:0] slot_reg;

    logic [7:0] p_i;
    logic [CB-1:0] x_i, y_i;
    logic [SW-1:0] slot_i;
    logic [3:0] gwin_i;
    logic [DB-1:0] gw_i, gh_i;

    logic [lzs_pkg::WSUM_BITS-1:0] ws_reg;
    logic [lzs_pkg::WSQ_BITS-1:0]  wq_reg;
    logic [lzs_pkg::CSUM_BITS-1:0] hs_reg [lzs_pkg::HIST_LEN];
    logic [lzs_pkg::CSQ_BITS-1:0]  hq_reg [lzs_pkg::HIST_LEN];

    logic [7:0]  line_mem [L*lzs_pkg::LINE_COLS];
    logic [31:0] col_mem  [lzs_pkg::LINE_COLS];
    logic [7:0]  line_rd;
    logic [31:0] col_rd;

    logic [CB-1:0] row_p, col_p;
    logic          last_p;
    logic          m_valid_reg, m_mark_reg, m_last_reg;
    logic [CB-1:0] m_row_reg, m_col_reg;

    lzs_pkg::req_t jreq;
    lzs_pkg::res_t jres;

    logic          accept;
    logic [CB-1:0] xe, ye;
    logic [SW-1:0] slote;
    logic [3:0]    gwin_e;
    logic [DB-1:0] gw_e, gh_e;
    logic [2:0]    r_i;
    logic [3:0]    d_i;
    logic [SW:0]   old_slot, ctr_slot;
    logic [SW+CB-1:0] rd_addr, wr_addr;
    logic [lzs_pkg::CSUM_BITS-1:0] prev_s, fs;
    logic [lzs_pkg::CSQ_BITS-1:0]  prev_q, fq;
    logic [7:0]    old_p;
    logic [HB-1:0] hidx;
    logic          emit, out_free, load_out;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (st_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (st_reg == ST_WAIT) && jres.done && out_free;

    always_comb begin
        xe     = s_tuser ? '0 : x_reg;
        ye     = s_tuser ? '0 : y_reg;
        slote  = s_tuser ? '0 : slot_reg;
        gwin_e = s_tuser ? lzs_pkg::clamp_win(win_reg, WCAP_V) : gwin_reg;
        gw_e   = s_tuser ? lzs_pkg::clamp_dim(w_reg, lzs_pkg::WIDTH_CAP) : gw_reg;
        gh_e   = s_tuser ? lzs_pkg::clamp_dim(h_reg, lzs_pkg::HEIGHT_CAP) : gh_reg;
        r_i    = gwin_i[3:1];
        d_i    = gwin_i - 4'd1;
        old_slot = ({1'b0, slot_i} >= (SW+1)'(d_i)) ? {1'b0, slot_i} - (SW+1)'(d_i)
                                                   : {1'b0, slot_i} + L_V - (SW+1)'(d_i);
        ctr_slot = ({1'b0, slot_i} >= (SW+1)'(r_i)) ? {1'b0, slot_i} - (SW+1)'(r_i)
                                                   : {1'b0, slot_i} + L_V - (SW+1)'(r_i);
        rd_addr = (st_reg == ST_READ) ? {old_slot[SW-1:0], x_i}
                                      : {ctr_slot[SW-1:0], CB'(x_i - CB'(r_i))};
        wr_addr = {slot_i, x_i};
        prev_s = (y_i == '0) ? '0 : col_rd[lzs_pkg::CSUM_BITS-1:0];
        prev_q = (y_i == '0) ? '0 : col_rd[31:lzs_pkg::CSUM_BITS];
        fs     = prev_s + lzs_pkg::CSUM_BITS'(p_i);
        fq     = prev_q + lzs_pkg::CSQ_BITS'(p_i) * lzs_pkg::CSQ_BITS'(p_i);
        old_p  = (y_i >= CB'(d_i)) ? line_rd : 8'd0;
        hidx   = HB'(x_i - CB'(gwin_i));
        emit   = (y_i >= CB'(d_i)) && (x_i >= CB'(d_i));
    end

    always_ff @(posedge aclk) begin
        line_rd <= line_mem[rd_addr];
        col_rd  <= col_mem[x_i];
        if (st_reg == ST_UPD) begin
            line_mem[wr_addr] <= p_i;
            col_mem[x_i] <= {fq - lzs_pkg::CSQ_BITS'(old_p) * lzs_pkg::CSQ_BITS'(old_p),
                             fs - lzs_pkg::CSUM_BITS'(old_p)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= lzs_pkg::WIN_RESET;
            thr_reg <= lzs_pkg::THR_RESET;
            w_reg   <= lzs_pkg::WIDTH_RESET;
            h_reg   <= lzs_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                lzs_pkg::REG_WINDOW: win_reg <= cfg_wdata[3:0];
                lzs_pkg::REG_THR:    thr_reg <= cfg_wdata;
                lzs_pkg::REG_WIDTH:  w_reg   <= cfg_wdata[DB-1:0];
                lzs_pkg::REG_HEIGHT: h_reg   <= cfg_wdata[DB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            x_reg    <= '0;
            y_reg    <= '0;
            slot_reg <= '0;
            gwin_reg <= lzs_pkg::clamp_win(lzs_pkg::WIN_RESET, WCAP_V);
            gw_reg   <= lzs_pkg::WIDTH_RESET;
            gh_reg   <= lzs_pkg::HEIGHT_RESET;
            ws_reg   <= '0;
            wq_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (accept) begin
                        p_i <= s_tdata;  x_i <= xe;  y_i <= ye;  slot_i <= slote;
                        gwin_i <= gwin_e;  gw_i <= gw_e;  gh_i <= gh_e;
                        if ({1'b0, xe} + DB'(1) >= gw_e) begin
                            x_reg <= '0;
                            if ({1'b0, ye} + DB'(1) >= gh_e) begin
                                y_reg    <= '0;
                                slot_reg <= '0;
                                gwin_reg <= lzs_pkg::clamp_win(win_reg, WCAP_V);
                                gw_reg   <= lzs_pkg::clamp_dim(w_reg, lzs_pkg::WIDTH_CAP);
                                gh_reg   <= lzs_pkg::clamp_dim(h_reg, lzs_pkg::HEIGHT_CAP);
                            end else begin
                                y_reg    <= ye + CB'(1);
                                slot_reg <= ({1'b0, slote} == L_V - (SW+1)'(1))
                                            ? '0 : slote + SW'(1);
                                gwin_reg <= gwin_e;  gw_reg <= gw_e;  gh_reg <= gh_e;
                            end
                        end else begin
                            x_reg <= xe + CB'(1);
                            y_reg <= ye;
                            slot_reg <= slote;
                            gwin_reg <= gwin_e;  gw_reg <= gw_e;  gh_reg <= gh_e;
                        end
                        st_reg <= ST_READ;
                    end
                end
                ST_READ: st_reg <= ST_UPD;
                ST_UPD: begin
                    if (x_i == '0) begin
                        ws_reg <= lzs_pkg::WSUM_BITS'(fs);
                        wq_reg <= lzs_pkg::WSQ_BITS'(fq);
                    end else if (x_i >= CB'(gwin_i)) begin
                        ws_reg <= ws_reg + lzs_pkg::WSUM_BITS'(fs)
                                  - lzs_pkg::WSUM_BITS'(hs_reg[hidx]);
                        wq_reg <= wq_reg + lzs_pkg::WSQ_BITS'(fq)
                                  - lzs_pkg::WSQ_BITS'(hq_reg[hidx]);
                    end else begin
                        ws_reg <= ws_reg + lzs_pkg::WSUM_BITS'(fs);
                        wq_reg <= wq_reg + lzs_pkg::WSQ_BITS'(fq);
                    end
                    hs_reg[x_i[HB-1:0]] <= fs;
                    hq_reg[x_i[HB-1:0]] <= fq;
                    row_p  <= y_i - CB'(r_i);
                    col_p  <= x_i - CB'(r_i);
                    last_p <= ({1'b0, y_i} == gh_i - DB'(1)) && ({1'b0, x_i} == gw_i - DB'(1));
                    st_reg <= emit ? ST_CTR : ST_IDLE;
                end
                ST_CTR: st_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (load_out) begin
                        m_mark_reg  <= jres.mark;
                        m_row_reg   <= row_p;
                        m_col_reg   <= col_p;
                        m_last_reg  <= last_p;
                        st_reg      <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        jreq.start = (st_reg == ST_CTR);
        jreq.ack   = load_out;
        jreq.s     = ws_reg;
        jreq.q     = wq_reg;
        jreq.n     = 8'(gwin_i) * 8'(gwin_i);
        jreq.c     = line_rd;
        jreq.t     = thr_reg;
    end

    lzs_judge u_judge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (jreq),
        .res     (jres)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_col_reg, m_row_reg, m_mark_reg};
    assign m_tlast  = m_last_reg;

    a_accept_judge_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !jres.busy && !jres.done) else $error("item taken during judge");
    a_upd_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_UPD) |=> (st_reg == ST_CTR || st_reg == ST_IDLE))
        else $error("bad step after update");
    a_load_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(jres.done)) else $error("result without judge");
endmodule
`default_nettype wire
